// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file hrp_checker.sv.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while out of reset
`define HRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every rising edge, reset included
`define HRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hrp_pkg.sv =====
// Shared types, phase codes and the hex digit decoder for the record parser.
// No dependencies.
package hrp_pkg;

  // Record layout phases
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_COUNT = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_TYPE  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CHECK = 3'd5;
  localparam logic [2:0] PH_TERM  = 3'd6;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Last digit position of the address field
  localparam logic [1:0] ADDR_LAST_NIB = 2'd3;

  // ASCII codes
  localparam logic [7:0] ASCII_0 = 8'h30;
  localparam logic [7:0] ASCII_9 = 8'h39;
  localparam logic [7:0] ASCII_A = 8'h41;
  localparam logic [7:0] ASCII_F = 8'h46;
  localparam logic [7:0] HEX_TEN = 8'd10;

  typedef struct packed {
    logic        kind;
    logic [15:0] record_address;
    logic [7:0]  rec_type;
    logic [7:0]  byte_count;
    logic [7:0]  byte_index;
    logic [7:0]  value;
  } result_t;

  // Uppercase hex digit to value; anything else reads as zero
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      if (c >= ASCII_0 && c <= ASCII_9) begin
        t = c - ASCII_0;
      end else if (c >= ASCII_A && c <= ASCII_F) begin
        t = c - ASCII_A + HEX_TEN;
      end else begin
        t = 8'd0;
      end
      return t[3:0];
    end
  endfunction

endpackage

// ===== hdl/hrp_ifs.sv =====
// Request channel interfaces of the record parser: characters in, results out.
// No dependencies.
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] record_address;
  logic [7:0]  rec_type;
  logic [7:0]  byte_count;
  logic [7:0]  byte_index;
  logic [7:0]  value;

  modport source (output valid, output kind, output record_address, output rec_type,
                  output byte_count, output byte_index, output value, input ready);
  modport sink   (input valid, input kind, input record_address, input rec_type,
                  input byte_count, input byte_index, input value, output ready);
endinterface

// ===== hdl/hrp_in_reg.sv =====
// Input register: holds one character request until the parser consumes it.
// No package dependencies.
module hrp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_char,
  output logic       in_ready,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_char
);

  logic       valid_r, valid_nxt;
  logic [7:0] char_r;

  // Free when empty or when the held character leaves this cycle
  assign in_ready   = !valid_r || take;
  assign held_valid = valid_r;
  assign held_char  = char_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char;
    end
  end

endmodule

// ===== hdl/hrp_parser.sv =====
// Record layout tracker: field registers, digit assembly and result forming.
// Depends on hrp_pkg.
module hrp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      char_in,
  output logic            emit,
  output hrp_pkg::result_t res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  nib_r, nib_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  index_r, index_nxt;
  logic [3:0]  high_r, high_nxt;

  logic [3:0]  d;
  logic [7:0]  byte_val;
  logic [7:0]  index_inc;
  logic        second;

  assign d         = hrp_pkg::digit_value(char_in);
  assign byte_val  = {high_r, d};
  assign index_inc = index_r + 8'd1;
  assign second    = nib_r[0];

  // Next field state and result for the current character
  always_comb begin
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    type_nxt  = type_r;
    index_nxt = index_r;
    high_nxt  = high_r;
    emit      = 1'b0;
    res.kind           = hrp_pkg::KIND_DATA;
    res.record_address = addr_r;
    res.rec_type       = type_r;
    res.byte_count     = count_r;
    res.byte_index     = index_r;
    res.value          = byte_val;

    unique case (phase_r)
      hrp_pkg::PH_COUNT: begin
        if (!second) begin
          high_nxt = d;
          nib_nxt  = 2'd1;
        end else begin
          count_nxt = byte_val;
          nib_nxt   = 2'd0;
          phase_nxt = hrp_pkg::PH_ADDR;
        end
      end
      hrp_pkg::PH_ADDR: begin
        addr_nxt = {addr_r[11:0], d};
        if (nib_r == hrp_pkg::ADDR_LAST_NIB) begin
          nib_nxt   = 2'd0;
          phase_nxt = hrp_pkg::PH_TYPE;
        end else begin
          nib_nxt = nib_r + 2'd1;
        end
      end
      hrp_pkg::PH_TYPE: begin
        if (!second) begin
          high_nxt = d;
          nib_nxt  = 2'd1;
        end else begin
          type_nxt  = byte_val;
          nib_nxt   = 2'd0;
          index_nxt = 8'd0;
          phase_nxt = (count_r == 8'd0) ? hrp_pkg::PH_CHECK : hrp_pkg::PH_DATA;
        end
      end
      hrp_pkg::PH_DATA: begin
        if (!second) begin
          high_nxt = d;
          nib_nxt  = 2'd1;
        end else begin
          nib_nxt   = 2'd0;
          emit      = 1'b1;
          index_nxt = index_inc;
          if (index_inc == count_r) begin
            phase_nxt = hrp_pkg::PH_CHECK;
          end
        end
      end
      hrp_pkg::PH_CHECK: begin
        if (!second) begin
          high_nxt = d;
          nib_nxt  = 2'd1;
        end else begin
          nib_nxt        = 2'd0;
          emit           = 1'b1;
          res.kind       = hrp_pkg::KIND_END;
          res.byte_index = 8'd0;
          phase_nxt      = hrp_pkg::PH_TERM;
        end
      end
      hrp_pkg::PH_TERM: begin
        phase_nxt = hrp_pkg::PH_START;
      end
      // Start character, and the unused code
      default: begin
        nib_nxt   = 2'd0;
        addr_nxt  = 16'd0;
        phase_nxt = hrp_pkg::PH_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrp_pkg::PH_START;
      nib_r   <= 2'd0;
      count_r <= 8'd0;
      addr_r  <= 16'd0;
      type_r  <= 8'd0;
      index_r <= 8'd0;
      high_r  <= 4'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
      type_r  <= type_nxt;
      index_r <= index_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

// ===== hdl/hrp_out_reg.sv =====
// Result register: holds one result request until the sink takes it.
// Depends on hrp_pkg.
module hrp_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  hrp_pkg::result_t res_in,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             free,
  output hrp_pkg::result_t res_out
);

  logic             valid_r, valid_nxt;
  hrp_pkg::result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

// ===== hdl/hex_record_parser.sv =====
// Top level of the hex-text record parser.
// Depends on hrp_pkg, hrp_ifs, hrp_in_reg, hrp_parser, hrp_out_reg.
//
//   channel   | dir | payload                                          | per request
//   in_chan   | in  | char_in                                          | one character
//   out_chan  | out | kind, record_address, rec_type, byte_count,      | zero or one
//             |     | byte_index, value                                | result
//
// One character per cycle sustained while the result register has room: each
// character is held in the input register, then the field update and result
// forming take one pass into the result register.
// Synchronous active-low reset clears the layout state and both valid flags.
// A stalled result holds only characters that would produce a result; other
// characters keep flowing through the layout tracker meanwhile.
module hex_record_parser (
  input  logic         clk,
  input  logic         rst_n,
  hrp_in_if.sink       in_chan,
  hrp_out_if.source    out_chan
);

  logic             held_valid;
  logic [7:0]       held_char;
  logic             take;
  logic             emit;
  logic             out_free;
  hrp_pkg::result_t res;
  hrp_pkg::result_t res_q;

  // A held character moves on unless its result would find the output full
  assign take = held_valid && (!emit || out_free);

  hrp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_char    (in_chan.char_in),
    .in_ready   (in_chan.ready),
    .take       (take),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  hrp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (take),
    .char_in (held_char),
    .emit    (emit),
    .res     (res)
  );

  hrp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && emit),
    .res_in    (res),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .free      (out_free),
    .res_out   (res_q)
  );

  assign out_chan.kind           = res_q.kind;
  assign out_chan.record_address = res_q.record_address;
  assign out_chan.rec_type       = res_q.rec_type;
  assign out_chan.byte_count     = res_q.byte_count;
  assign out_chan.byte_index     = res_q.byte_index;
  assign out_chan.value          = res_q.value;

endmodule

// ===== hdl/hrp_checker.sv =====
// Port-level checks on the record parser, bound to the top level.
// Depends on assert_macros.svh and hex_record_parser.
`include "assert_macros.svh"

module hrp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_byte_count,
  input logic [7:0] out_byte_index,
  input logic [7:0] out_value
);

  // A stalled result keeps its request up and its byte unchanged
  `HRP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_value), "stalled result dropped or changed")

  // Record end always reports index zero
  `HRP_ASSERT(a_end_index, out_valid && out_kind |-> out_byte_index == 8'd0, "record end with nonzero index")

  // Data bytes stay inside the declared count
  `HRP_ASSERT(a_data_index, out_valid && !out_kind |-> out_byte_index < out_byte_count, "data index beyond byte count")

  // Nothing is offered right after reset
  `HRP_ASSERT_ALWAYS(a_reset_idle, $past(!rst_n) |-> !out_valid, "result offered after reset")

endmodule

bind hex_record_parser hrp_checker u_hrp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_kind       (out_chan.kind),
  .out_byte_count (out_chan.byte_count),
  .out_byte_index (out_chan.byte_index),
  .out_value      (out_chan.value)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for hex_record_parser: streams hex-text records through the character channel.
// It predicts every data byte and record end, and checks them against the result channel.
// Depends on hrp_pkg, hrp_ifs and the parser RTL.
module tb;
  import hrp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TARGET_CHARS = 826;
  localparam int SHOWN_ERRORS = 10;

  logic clk;
  logic rst_n;

  hrp_in_if  in_chan ();
  hrp_out_if out_chan ();

  hex_record_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Character stream waiting to be sent, and results the parser still owes
  logic [7:0] char_stream[$];
  result_t    due_results[$];

  // Layout tracker state, mirrors the parser
  logic [2:0]  lay_phase = PH_START;
  logic [1:0]  nib_pos   = 2'd0;
  logic [7:0]  cnt_q     = 8'd0;
  logic [15:0] addr_q    = 16'd0;
  logic [7:0]  type_q    = 8'd0;
  logic [7:0]  idx_q     = 8'd0;
  logic [3:0]  hi_nib    = 4'd0;

  int errors       = 0;
  int chars_sent   = 0;
  int data_seen    = 0;
  int ends_seen    = 0;
  int records_made = 0;
  int idle_cycles  = 0;
  bit char_taken   = 1'b0;
  int send_gap     = 0;
  int send_calm    = 0;
  int stall_left   = 0;
  int sink_calm    = 0;

  always #4 clk = ~clk;

  // Uppercase hex digit to its value; the low nibble of '0'..'9' is the value itself
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c >= ASCII_0 && c <= ASCII_9) begin
      return c[3:0];
    end else if (c >= ASCII_A && c <= ASCII_F) begin
      return c[3:0] + 4'd9;
    end
    return 4'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return ASCII_0 + n;
    end
    return ASCII_A + n - 4'd10;
  endfunction

  // Digit character, sometimes replaced by lowercase or an arbitrary byte
  function automatic logic [7:0] digit_char(input logic [3:0] n, input int noise_pct);
    if ($urandom_range(0, 99) >= noise_pct) begin
      return hex_char(n);
    end else if ($urandom_range(0, 1) == 0) begin
      return 8'h61 + 8'($urandom_range(0, 5));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Idle length: mostly none, some short, a few long, with calm runs of no idling
  function automatic int next_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end else if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  task automatic push_byte_digits(input logic [7:0] b);
    char_stream.push_back(hex_char(b[7:4]));
    char_stream.push_back(hex_char(b[3:0]));
  endtask

  // One record; the data length follows what the count digits really decode to
  task automatic gen_record(input logic [7:0] want_count, input int noise_pct);
    logic [7:0] c_hi;
    logic [7:0] c_lo;
    logic [7:0] n;
    logic [7:0] t;
    int i;
    char_stream.push_back(8'($urandom_range(0, 255)));
    c_hi = digit_char(want_count[7:4], noise_pct);
    c_lo = digit_char(want_count[3:0], noise_pct);
    char_stream.push_back(c_hi);
    char_stream.push_back(c_lo);
    n = {hex_nibble(c_hi), hex_nibble(c_lo)};
    for (i = 0; i < 4; i++) begin
      char_stream.push_back(digit_char(4'($urandom_range(0, 15)), noise_pct));
    end
    t = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 5));
    char_stream.push_back(digit_char(t[7:4], noise_pct));
    char_stream.push_back(digit_char(t[3:0], noise_pct));
    for (i = 0; i < 2 * int'(n) + 2; i++) begin
      char_stream.push_back(digit_char(4'($urandom_range(0, 15)), noise_pct));
    end
    char_stream.push_back(8'($urandom_range(0, 255)));
    records_made++;
  endtask

  // Advance the layout by one character and queue any result it completes
  task automatic parse_char(input logic [7:0] c);
    logic [3:0] d;
    logic [7:0] pair;
    result_t r;
    d = hex_nibble(c);
    pair = {hi_nib, d};
    case (lay_phase)
      PH_COUNT: begin
        if (!nib_pos[0]) begin
          hi_nib = d;
          nib_pos = 2'd1;
        end else begin
          cnt_q = pair;
          nib_pos = 2'd0;
          lay_phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        addr_q = {addr_q[11:0], d};
        if (nib_pos == ADDR_LAST_NIB) begin
          nib_pos = 2'd0;
          lay_phase = PH_TYPE;
        end else begin
          nib_pos = nib_pos + 2'd1;
        end
      end
      PH_TYPE: begin
        if (!nib_pos[0]) begin
          hi_nib = d;
          nib_pos = 2'd1;
        end else begin
          type_q = pair;
          nib_pos = 2'd0;
          idx_q = 8'd0;
          lay_phase = (cnt_q == 8'd0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        if (!nib_pos[0]) begin
          hi_nib = d;
          nib_pos = 2'd1;
        end else begin
          nib_pos = 2'd0;
          r = {KIND_DATA, addr_q, type_q, cnt_q, idx_q, pair};
          due_results.push_back(r);
          data_seen++;
          idx_q = idx_q + 8'd1;
          if (idx_q == cnt_q) begin
            lay_phase = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        if (!nib_pos[0]) begin
          hi_nib = d;
          nib_pos = 2'd1;
        end else begin
          nib_pos = 2'd0;
          r = {KIND_END, addr_q, type_q, cnt_q, 8'd0, pair};
          due_results.push_back(r);
          ends_seen++;
          lay_phase = PH_TERM;
        end
      end
      PH_TERM: begin
        lay_phase = PH_START;
      end
      default: begin
        nib_pos = 2'd0;
        addr_q = 16'd0;
        lay_phase = PH_COUNT;
      end
    endcase
  endtask

  // Character driver, changes at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (in_chan.valid && !char_taken) begin
      // request still waiting for ready
    end else if (send_gap > 0) begin
      in_chan.valid <= 1'b0;
      send_gap = send_gap - 1;
    end else if (char_stream.size() > 0) begin
      in_chan.valid <= 1'b1;
      in_chan.char_in <= char_stream.pop_front();
      send_gap = next_gap(send_calm);
    end else begin
      in_chan.valid <= 1'b0;
    end
    char_taken = 1'b0;
  end

  // Result sink stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_chan.ready <= 1'b1;
      stall_left = next_gap(sink_calm);
    end
  end

  // Predict on accepted characters, check accepted results, watch for a hang
  always @(posedge clk) begin
    result_t got;
    result_t want;
    bit moved;
    moved = 1'b0;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      char_taken = 1'b1;
      chars_sent++;
      moved = 1'b1;
      parse_char(in_chan.char_in);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      moved = 1'b1;
      got = {out_chan.kind, out_chan.record_address, out_chan.rec_type,
             out_chan.byte_count, out_chan.byte_index, out_chan.value};
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS) begin
          $display("unexpected result: kind %0d addr %h type %h count %h idx %h value %h",
                   got.kind, got.record_address, got.rec_type, got.byte_count,
                   got.byte_index, got.value);
        end
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= SHOWN_ERRORS) begin
            $display("mismatch: kind %0d/%0d addr %h/%h type %h/%h count %h/%h idx %h/%h value %h/%h",
                     want.kind, got.kind, want.record_address, got.record_address,
                     want.rec_type, got.rec_type, want.byte_count, got.byte_count,
                     want.byte_index, got.byte_index, want.value, got.value);
          end
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int rec;
    int pick;
    clk = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.char_in = 8'h00;
    out_chan.ready = 1'b0;

    // Zero byte count: type goes straight to checksum
    char_stream.push_back(8'h3A);
    push_byte_digits(8'h00);
    push_byte_digits(8'h00);
    push_byte_digits(8'h00);
    push_byte_digits(8'h01);
    push_byte_digits(8'hFF);
    char_stream.push_back(8'h0A);
    // Top address and type, lowercase and just-outside-range digits decode as zero
    char_stream.push_back(8'h00);
    push_byte_digits(8'h01);
    push_byte_digits(8'hFF);
    push_byte_digits(8'hFF);
    push_byte_digits(8'hFF);
    char_stream.push_back(8'h39);
    char_stream.push_back(8'h66);
    char_stream.push_back(8'h2F);
    char_stream.push_back(8'h47);
    char_stream.push_back(8'hFF);
    records_made += 2;

    // Random records, mostly well formed, one long one, some pure noise
    rec = 0;
    while (char_stream.size() < TARGET_CHARS) begin
      pick = $urandom_range(0, 99);
      if (rec == 15) begin
        gen_record(8'($urandom_range(128, 255)), 0);
      end else if (pick < 10) begin
        gen_record(8'($urandom_range(0, 255)), 100);
      end else if (pick < 65) begin
        gen_record(8'($urandom_range(0, 4)), 5);
      end else if (pick < 93) begin
        gen_record(8'($urandom_range(5, 16)), 5);
      end else begin
        gen_record(8'($urandom_range(17, 40)), 5);
      end
      rec++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_stream.size() != 0 || in_chan.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    errors += due_results.size();
    $display("sent %0d characters in %0d records", chars_sent, records_made);
    $display("predicted %0d data bytes and %0d record ends, %0d errors",
             data_seen, ends_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
